// ----- sv/clrq_pkg.sv -----
// shared types and constants for the crlf line receiver with command queue
`default_nettype none

package clrq_pkg;

  typedef enum logic [2:0] {
    KIND_TAKEN   = 3'd0,
    KIND_QUEUED  = 3'd1,
    KIND_DROPPED = 3'd2,
    KIND_BADTERM = 3'd3,
    KIND_CMDBYTE = 3'd4,
    KIND_EMPTY   = 3'd5
  } kind_t;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  localparam int JQ_DEPTH = 2;
  // slots beyond the queue depth: the line being built plus every take in flight
  localparam int RING_SPARE = JQ_DEPTH + 2;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  cmd_length;
    logic [3:0]  pending;
  } job_t;

endpackage

`default_nettype wire

// ----- sv/crlf_line_receiver_with_command_queue_top.sv -----
// top level: crlf line receiver feeding a command queue
//
//   channel  ports                                   direction
//   in       in_valid in_stall in_op in_rx_byte      item in
//   out      out_valid out_stall out_kind out_data   result out
//            out_has_data out_cmd_length
//            out_pending_count out_last
//
// an item is accepted while the two-entry job queue has room; in_stall rises only
// while the job queue is full; stores need no clearing after reset; a received byte
// or an empty take gives its result via the job queue and the output register; a
// command take gives its first byte via the S_LEN and S_EMIT states, then one byte
// per cycle while out_stall is low, set by the single read port of the byte store
`default_nettype none

module crlf_line_receiver_with_command_queue_top
  import clrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int LINE_MAX    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data,
  output logic             out_has_data,
  output logic [5:0]       out_cmd_length,
  output logic [3:0]       out_pending_count,
  output logic             out_last
);

  localparam int RING = QUEUE_DEPTH + RING_SPARE;
  localparam int SW   = $clog2(RING);
  localparam int IW   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
  localparam int LW   = $clog2(LINE_MAX + 1);

  logic             jq_full, jq_push, jq_valid, jq_pop;
  job_t             job_in, job_out;
  logic             bw_en, lw_en;
  logic [SW+IW-1:0] bw_addr;
  logic [7:0]       bw_data;
  logic [SW-1:0]    lw_slot;
  logic [LW-1:0]    lw_len;

  clrq_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LINE_MAX    (LINE_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_rx_byte (in_rx_byte),
    .jq_full    (jq_full),
    .push       (jq_push),
    .job        (job_in),
    .bw_en      (bw_en),
    .bw_addr    (bw_addr),
    .bw_data    (bw_data),
    .lw_en      (lw_en),
    .lw_slot    (lw_slot),
    .lw_len     (lw_len)
  );

  clrq_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (jq_push),
    .job_in  (job_in),
    .full    (jq_full),
    .pop     (jq_pop),
    .valid   (jq_valid),
    .job_out (job_out)
  );

  clrq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LINE_MAX    (LINE_MAX)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (jq_valid),
    .job               (job_out),
    .pop               (jq_pop),
    .bw_en             (bw_en),
    .bw_addr           (bw_addr),
    .bw_data           (bw_data),
    .lw_en             (lw_en),
    .lw_slot           (lw_slot),
    .lw_len            (lw_len),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_data          (out_data),
    .out_has_data      (out_has_data),
    .out_cmd_length    (out_cmd_length),
    .out_pending_count (out_pending_count),
    .out_last          (out_last)
  );

`ifndef NO_ASSERTIONS
  a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_CMDBYTE) |-> out_last && !out_has_data)
    else $error("non command result without last marker");

  a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> (out_data == 8'd0))
    else $error("data not zero without has_data");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid && (out_kind == KIND_CMDBYTE))
    else $error("command burst broken before last byte");

  a_empty_cmd_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_CMDBYTE) && !out_has_data |-> out_last)
    else $error("empty command not marked last");
`endif

endmodule

`default_nettype wire

// ----- sv/clrq_front.sv -----
// front end: accepts items, assembles lines and classifies each item into a job
`default_nettype none

module clrq_front
  import clrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int LINE_MAX    = 32,
  localparam int RING = QUEUE_DEPTH + RING_SPARE,
  localparam int SW   = $clog2(RING),
  localparam int IW   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
  localparam int LW   = $clog2(LINE_MAX + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            in_op,
  input  wire logic [7:0]      in_rx_byte,
  input  wire logic            jq_full,
  output logic                 push,
  output job_t                 job,
  output logic                 bw_en,
  output logic [SW+IW-1:0]     bw_addr,
  output logic [7:0]           bw_data,
  output logic                 lw_en,
  output logic [SW-1:0]        lw_slot,
  output logic [LW-1:0]        lw_len
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          accept;
  logic [LW-1:0] len_r, len_nxt;
  logic          cr_r, cr_nxt;
  logic [SW-1:0] wslot_r, wslot_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign in_stall = jq_full;
  assign accept   = in_valid && !jq_full;
  assign push     = accept;
  assign bw_addr  = {wslot_r, len_r[IW-1:0]};
  assign bw_data  = in_rx_byte;
  assign lw_slot  = wslot_r;
  assign lw_len   = len_r;

  always_comb begin
    len_nxt        = len_r;
    cr_nxt         = cr_r;
    wslot_nxt      = wslot_r;
    count_nxt      = count_r;
    job.kind       = KIND_TAKEN;
    job.cmd_length = '0;
    bw_en          = 1'b0;
    lw_en          = 1'b0;
    if (accept) begin
      if (!in_op) begin
        if (cr_r) begin
          cr_nxt  = 1'b0;
          len_nxt = '0;
          if (in_rx_byte != CH_LF) begin
            job.kind = KIND_BADTERM;
          end else if (count_r < CW'(QUEUE_DEPTH)) begin
            lw_en          = 1'b1;
            wslot_nxt      = (wslot_r == SW'(RING - 1)) ? '0 : wslot_r + 1'b1;
            count_nxt      = count_r + 1'b1;
            job.kind       = KIND_QUEUED;
            job.cmd_length = 6'(len_r);
          end else begin
            job.kind       = KIND_DROPPED;
            job.cmd_length = 6'(len_r);
          end
        end else begin
          if (in_rx_byte == CH_CR) begin
            cr_nxt = 1'b1;
          end else if (len_r < LW'(LINE_MAX)) begin
            bw_en   = 1'b1;
            len_nxt = len_r + 1'b1;
          end
        end
      end else begin
        if (count_r == '0) begin
          job.kind = KIND_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
          job.kind  = KIND_CMDBYTE;
        end
      end
    end
    job.pending = 4'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      cr_r    <= 1'b0;
      wslot_r <= '0;
      count_r <= '0;
    end else begin
      len_r   <= len_nxt;
      cr_r    <= cr_nxt;
      wslot_r <= wslot_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/clrq_jobq.sv -----
// short job queue between front end and back end
`default_nettype none

module clrq_jobq
  import clrq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  job_t       job_in,
  output logic       full,
  input  wire logic  pop,
  output logic       valid,
  output job_t       job_out
);

  localparam int PW = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
  localparam int NW = $clog2(JQ_DEPTH + 1);

  job_t          q_r [JQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == NW'(JQ_DEPTH));
  assign valid   = (cnt_r != '0);
  assign job_out = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(JQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(JQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + NW'(do_push) - NW'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ----- sv/clrq_back.sv -----
// back end: command store and result sequencer with output register
`default_nettype none

module clrq_back
  import clrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int LINE_MAX    = 32,
  localparam int RING = QUEUE_DEPTH + RING_SPARE,
  localparam int SW   = $clog2(RING),
  localparam int IW   = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
  localparam int LW   = $clog2(LINE_MAX + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  input  job_t                   job,
  output logic                   pop,
  input  wire logic              bw_en,
  input  wire logic [SW+IW-1:0]  bw_addr,
  input  wire logic [7:0]        bw_data,
  input  wire logic              lw_en,
  input  wire logic [SW-1:0]     lw_slot,
  input  wire logic [LW-1:0]     lw_len,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             out_kind,
  output logic [7:0]             out_data,
  output logic                   out_has_data,
  output logic [5:0]             out_cmd_length,
  output logic [3:0]             out_pending_count,
  output logic                   out_last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_EMIT
  } state_t;

  logic [7:0]    byte_mem_r [RING * (2 ** IW)];
  logic [LW-1:0] len_mem_r [RING];

  state_t        state_r;
  logic [SW-1:0] rslot_r, rslot_inc;
  logic [LW-1:0] idx_r;
  logic [LW-1:0] len_rd_r;
  logic [7:0]    rd_byte_r;
  logic [3:0]    pend_r;

  logic          out_valid_r, out_valid_nxt;
  kind_t         out_kind_r;
  logic [7:0]    out_data_r;
  logic          out_has_r;
  logic [5:0]    out_len_r;
  logic [3:0]    out_pend_r;
  logic          out_last_r;

  logic             out_free;
  logic             out_load;
  logic             start_cmd;
  logic             rd_en;
  logic [SW+IW-1:0] rd_addr;
  logic             last_byte;

  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = (state_r == S_IDLE) && job_valid && out_free;
  assign start_cmd = pop && (job.kind == KIND_CMDBYTE);
  assign rslot_inc = (rslot_r == SW'(RING - 1)) ? '0 : rslot_r + 1'b1;
  assign last_byte = ((idx_r + 1'b1) == len_rd_r);

  // a new result enters the output register
  assign out_load = ((state_r == S_IDLE) && pop && (job.kind != KIND_CMDBYTE)) ||
                    ((state_r == S_LEN) && (len_rd_r == '0) && out_free) ||
                    ((state_r == S_EMIT) && out_free);
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {rslot_r, IW'(0)};
    if (start_cmd) begin
      rd_en = 1'b1;
    end else if ((state_r == S_EMIT) && out_free) begin
      rd_en   = 1'b1;
      rd_addr = {rslot_r, IW'(idx_r + 1'b1)};
    end
  end

  always_ff @(posedge clk) begin
    if (bw_en) begin
      byte_mem_r[bw_addr] <= bw_data;
    end
    if (lw_en) begin
      len_mem_r[lw_slot] <= lw_len;
    end
    if (rd_en) begin
      rd_byte_r <= byte_mem_r[rd_addr];
    end
    if (start_cmd) begin
      len_rd_r <= len_mem_r[rslot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rslot_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            if (job.kind == KIND_CMDBYTE) begin
              pend_r  <= job.pending;
              state_r <= S_LEN;
            end else begin
              out_kind_r  <= job.kind;
              out_data_r  <= '0;
              out_has_r   <= 1'b0;
              out_len_r   <= job.cmd_length;
              out_pend_r  <= job.pending;
              out_last_r  <= 1'b1;
            end
          end
        end
        S_LEN: begin
          if (len_rd_r == '0) begin
            if (out_free) begin
              out_kind_r  <= KIND_CMDBYTE;
              out_data_r  <= '0;
              out_has_r   <= 1'b0;
              out_len_r   <= '0;
              out_pend_r  <= pend_r;
              out_last_r  <= 1'b1;
              rslot_r     <= rslot_inc;
              state_r     <= S_IDLE;
            end
          end else begin
            idx_r   <= '0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_kind_r  <= KIND_CMDBYTE;
            out_data_r  <= rd_byte_r;
            out_has_r   <= 1'b1;
            out_len_r   <= 6'(len_rd_r);
            out_pend_r  <= pend_r;
            out_last_r  <= last_byte;
            idx_r       <= idx_r + 1'b1;
            if (last_byte) begin
              rslot_r <= rslot_inc;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_data          = out_data_r;
  assign out_has_data      = out_has_r;
  assign out_cmd_length    = out_len_r;
  assign out_pending_count = out_pend_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire
